@@ rtl/core/vpa_pkg.sv @@
// Package for the variable partition allocator.
// Holds shared constants, codes and the structs used by the cell chains.
package vpa_pkg;

   localparam int FREE_ENTRIES_DEF = 64;
   localparam int USED_ENTRIES_DEF = 64;

   localparam logic [16:0] RST_MEM_SIZE  = 17'd1024;
   localparam logic [15:0] RST_MEM_BASE  = 16'd0;
   localparam logic [1:0]  RST_POLICY    = 2'd0;
   localparam logic [15:0] RST_MIN_SLICE = 16'd10;
   localparam logic [16:0] MAX_MEM_SIZE  = 17'd65536;
   localparam logic [16:0] MIN_MEM_SIZE  = 17'd1;

   localparam logic [1:0] REG_MEM_SIZE   = 2'd0;
   localparam logic [1:0] REG_MEM_BASE   = 2'd1;
   localparam logic [1:0] REG_FIT_POLICY = 2'd2;
   localparam logic [1:0] REG_MIN_SLICE  = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NO_FIT    = 3'd1;
   localparam logic [2:0] STAT_BAD_SIZE  = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_FULL      = 3'd4;

   typedef struct packed {
      logic        en;
      logic [16:0] start;
      logic [16:0] len;
   } vpa_init_type;

   typedef struct packed {
      logic        en;
      logic        valid;
      logic [16:0] start;
      logic [16:0] len;
   } vpa_fwr_type;

   typedef struct packed {
      logic        en;
      logic        valid;
      logic [15:0] owner;
      logic [16:0] start;
      logic [16:0] len;
   } vpa_uwr_type;

   typedef struct packed {
      logic        has_best;
      logic [16:0] best_start;
      logic [16:0] best_len;
      logic        has_prev;
      logic [16:0] prev_start;
      logic [16:0] prev_len;
      logic        has_next;
      logic [16:0] next_len;
      logic        has_spare;
   } vpa_fpkt_type;

   typedef struct packed {
      logic        has_slot;
      logic        found;
      logic [16:0] found_start;
      logic [16:0] found_len;
   } vpa_upkt_type;

endpackage

@@ rtl/core/vpa_free_cell.sv @@
// One free-table cell: holds one free block and updates the search item passing by.
// Depends on vpa_pkg.
module vpa_free_cell #(
   parameter int IW = 6,
   parameter logic [IW-1:0] IDX = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vpa_pkg::vpa_init_type init,
   input  vpa_pkg::vpa_fwr_type  wr,
   input  logic [IW-1:0]         wr_idx,
   input  logic                  clr_en,
   input  logic [IW-1:0]         clr_idx,
   input  logic [16:0]           size,
   input  logic [16:0]           bs,
   input  logic [16:0]           bl,
   input  logic [1:0]            policy,
   input  vpa_pkg::vpa_fpkt_type pkt_in,
   input  logic [IW-1:0]         best_idx_in,
   input  logic [IW-1:0]         prev_idx_in,
   input  logic [IW-1:0]         next_idx_in,
   input  logic [IW-1:0]         spare_idx_in,
   output vpa_pkg::vpa_fpkt_type pkt_out,
   output logic [IW-1:0]         best_idx_out,
   output logic [IW-1:0]         prev_idx_out,
   output logic [IW-1:0]         next_idx_out,
   output logic [IW-1:0]         spare_idx_out
);

   logic                  valid_ff;
   logic [16:0]           start_ff;
   logic [16:0]           len_ff;
   vpa_pkg::vpa_fpkt_type pkt_ff, pkt_in_c;
   logic [IW-1:0]         best_ff, prev_ff, next_ff, spare_ff;
   logic [IW-1:0]         best_in, prev_in, next_in, spare_in;
   logic [17:0]           end_sum, blk_end;
   logic                  fit, better;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= (IDX == '0);
         start_ff <= {1'b0, vpa_pkg::RST_MEM_BASE};
         len_ff   <= vpa_pkg::RST_MEM_SIZE;
      end else if (init.en) begin
         valid_ff <= (IDX == '0);
         start_ff <= init.start;
         len_ff   <= init.len;
      end else begin
         if (clr_en && clr_idx == IDX) begin
            valid_ff <= 1'b0;
         end
         if (wr.en && wr_idx == IDX) begin
            valid_ff <= wr.valid;
            start_ff <= wr.start;
            len_ff   <= wr.len;
         end
      end
   end

   assign end_sum = {1'b0, start_ff} + {1'b0, len_ff};
   assign blk_end = {1'b0, bs} + {1'b0, bl};
   assign fit     = valid_ff && (len_ff >= size);

   always_comb begin
      case (policy)
         vpa_pkg::FIT_BEST: begin
            better = (len_ff < pkt_in.best_len) ||
                     ((len_ff == pkt_in.best_len) && (start_ff < pkt_in.best_start));
         end
         vpa_pkg::FIT_WORST: begin
            better = (len_ff > pkt_in.best_len) ||
                     ((len_ff == pkt_in.best_len) && (start_ff < pkt_in.best_start));
         end
         default: begin
            better = start_ff < pkt_in.best_start;
         end
      endcase
   end

   always_comb begin
      pkt_in_c = pkt_in;
      best_in  = best_idx_in;
      prev_in  = prev_idx_in;
      next_in  = next_idx_in;
      spare_in = spare_idx_in;
      if (fit && (!pkt_in.has_best || better)) begin
         pkt_in_c.has_best   = 1'b1;
         pkt_in_c.best_start = start_ff;
         pkt_in_c.best_len   = len_ff;
         best_in             = IDX;
      end
      if (!valid_ff && !pkt_in.has_spare) begin
         pkt_in_c.has_spare = 1'b1;
         spare_in           = IDX;
      end
      if (valid_ff) begin
         if (end_sum == {1'b0, bs}) begin
            pkt_in_c.has_prev   = 1'b1;
            pkt_in_c.prev_start = start_ff;
            pkt_in_c.prev_len   = len_ff;
            prev_in             = IDX;
         end else if ({1'b0, start_ff} == blk_end) begin
            pkt_in_c.has_next = 1'b1;
            pkt_in_c.next_len = len_ff;
            next_in           = IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff   <= pkt_in_c;
      best_ff  <= best_in;
      prev_ff  <= prev_in;
      next_ff  <= next_in;
      spare_ff <= spare_in;
   end

   assign pkt_out       = pkt_ff;
   assign best_idx_out  = best_ff;
   assign prev_idx_out  = prev_ff;
   assign next_idx_out  = next_ff;
   assign spare_idx_out = spare_ff;

endmodule

@@ rtl/core/vpa_used_cell.sv @@
// One used-table cell: holds one allocated block and updates the lookup item passing by.
// Depends on vpa_pkg.
module vpa_used_cell #(
   parameter int IW = 6,
   parameter logic [IW-1:0] IDX = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  init_en,
   input  vpa_pkg::vpa_uwr_type  wr,
   input  logic [IW-1:0]         wr_idx,
   input  logic [15:0]           pid,
   input  vpa_pkg::vpa_upkt_type pkt_in,
   input  logic [IW-1:0]         slot_idx_in,
   input  logic [IW-1:0]         found_idx_in,
   output vpa_pkg::vpa_upkt_type pkt_out,
   output logic [IW-1:0]         slot_idx_out,
   output logic [IW-1:0]         found_idx_out
);

   logic                  valid_ff;
   logic [15:0]           owner_ff;
   logic [16:0]           start_ff;
   logic [16:0]           len_ff;
   vpa_pkg::vpa_upkt_type pkt_ff, pkt_in_c;
   logic [IW-1:0]         slot_ff, found_ff, slot_in, found_in;

   always_ff @(posedge clock) begin
      if (reset || init_en) begin
         valid_ff <= 1'b0;
      end else if (wr.en && wr_idx == IDX) begin
         valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.valid && wr_idx == IDX) begin
         owner_ff <= wr.owner;
         start_ff <= wr.start;
         len_ff   <= wr.len;
      end
   end

   always_comb begin
      pkt_in_c = pkt_in;
      slot_in  = slot_idx_in;
      found_in = found_idx_in;
      if (!valid_ff && !pkt_in.has_slot) begin
         pkt_in_c.has_slot = 1'b1;
         slot_in           = IDX;
      end
      if (valid_ff && owner_ff == pid && !pkt_in.found) begin
         pkt_in_c.found       = 1'b1;
         pkt_in_c.found_start = start_ff;
         pkt_in_c.found_len   = len_ff;
         found_in             = IDX;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff   <= pkt_in_c;
      slot_ff  <= slot_in;
      found_ff <= found_in;
   end

   assign pkt_out       = pkt_ff;
   assign slot_idx_out  = slot_ff;
   assign found_idx_out = found_ff;

endmodule

@@ rtl/core/variable_partition_allocator.sv @@
// Variable partition allocator top level: control, configuration and the two cell chains.
// Depends on vpa_pkg, vpa_free_cell and vpa_used_cell.
//
// Usage: an item on the req_ channel is either an allocate (req_type 0, req_size)
// or a free by process id (req_type 1, req_pid). Each item yields exactly one item
// on the rsp_ channel with status, granted process id, block start and block size.
// Items are taken one at a time; req_stall is low only while the block is idle.
// A lookup item walks the used-cell chain and then the free-cell chain, one cell
// per cycle; rsp_valid rises once both chains have been walked and the result has
// been committed, and the next item can be accepted only once the block is back
// in idle, that is after the previous item has been committed.
// The result sits in an output register; a new item is accepted while it waits,
// and the next result is committed only once the previous one has been taken.
// A stalled result holds its value until rsp_stall falls.
// After reset the free table holds one block of 1024 units at address 0, the used
// table is empty and the first granted process id is 1. Writing the size or base
// register sets both tables back to one free block of the configured size at the
// configured base at once. Configuration is written through csr_we, csr_index and
// csr_wdata; the user must write it only while idle, as the block does not enforce it.
module variable_partition_allocator #(
   parameter int FREE_ENTRIES = vpa_pkg::FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = vpa_pkg::USED_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [16:0] req_size,
   input  logic [15:0] req_pid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_granted_pid,
   output logic [16:0] rsp_block_start,
   output logic [16:0] rsp_block_size,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int FIW      = $clog2(FREE_ENTRIES);
   localparam int UIW      = $clog2(USED_ENTRIES);
   localparam int SCAN_CYC = USED_ENTRIES + FREE_ENTRIES;
   localparam int CW       = $clog2(SCAN_CYC + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } vpa_state_type;

   vpa_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [16:0] region_size_ff;
   logic [15:0] mem_base_ff;
   logic [1:0]  policy_ff;
   logic [15:0] min_slice_ff;
   logic [15:0] next_pid_ff;

   logic        type_ff;
   logic [16:0] size_ff;
   logic [15:0] pid_ff;
   logic [15:0] gpid_ff;

   logic        rsp_valid_ff;
   logic [2:0]  status_ff;
   logic [15:0] rsp_pid_ff;
   logic [16:0] start_ff;
   logic [16:0] len_ff;

   logic        accept, commit_go;
   logic [16:0] size_clamped;

   vpa_pkg::vpa_init_type init;
   vpa_pkg::vpa_fwr_type  fwr;
   logic [FIW-1:0]        fwr_idx, clr_idx;
   logic                  clr_en;
   vpa_pkg::vpa_uwr_type  uwr;
   logic [UIW-1:0]        uwr_idx;

   logic [2:0]  c_status;
   logic [16:0] c_start, c_len, left;
   logic [18:0] merge_len;

   vpa_pkg::vpa_fpkt_type fpkt   [FREE_ENTRIES+1];
   logic [FIW-1:0]        f_best [FREE_ENTRIES+1];
   logic [FIW-1:0]        f_prev [FREE_ENTRIES+1];
   logic [FIW-1:0]        f_next [FREE_ENTRIES+1];
   logic [FIW-1:0]        f_spare[FREE_ENTRIES+1];
   vpa_pkg::vpa_upkt_type upkt   [USED_ENTRIES+1];
   logic [UIW-1:0]        u_slot [USED_ENTRIES+1];
   logic [UIW-1:0]        u_found[USED_ENTRIES+1];

   vpa_pkg::vpa_fpkt_type fo;
   vpa_pkg::vpa_upkt_type uo;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (csr_wdata == '0) begin
         size_clamped = vpa_pkg::MIN_MEM_SIZE;
      end else if (csr_wdata > vpa_pkg::MAX_MEM_SIZE) begin
         size_clamped = vpa_pkg::MAX_MEM_SIZE;
      end else begin
         size_clamped = csr_wdata;
      end
   end

   always_comb begin
      init.en    = csr_we && (csr_index == vpa_pkg::REG_MEM_SIZE ||
                              csr_index == vpa_pkg::REG_MEM_BASE);
      init.start = {1'b0, mem_base_ff};
      init.len   = region_size_ff;
      if (csr_index == vpa_pkg::REG_MEM_SIZE) begin
         init.len = size_clamped;
      end else begin
         init.start = {1'b0, csr_wdata[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_size_ff <= vpa_pkg::RST_MEM_SIZE;
         mem_base_ff    <= vpa_pkg::RST_MEM_BASE;
         policy_ff      <= vpa_pkg::RST_POLICY;
         min_slice_ff   <= vpa_pkg::RST_MIN_SLICE;
      end else if (csr_we) begin
         case (csr_index)
            vpa_pkg::REG_MEM_SIZE:   region_size_ff <= size_clamped;
            vpa_pkg::REG_MEM_BASE:   mem_base_ff    <= csr_wdata[15:0];
            vpa_pkg::REG_FIT_POLICY: policy_ff      <= csr_wdata[1:0];
            vpa_pkg::REG_MIN_SLICE:  min_slice_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               cnt_in   = CW'(SCAN_CYC);
            end
         end
         S_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_COMMIT: begin
            if (commit_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         next_pid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (accept && req_type == vpa_pkg::REQ_ALLOC) begin
            next_pid_ff <= next_pid_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         size_ff <= req_size;
         pid_ff  <= req_pid;
         gpid_ff <= (req_type == vpa_pkg::REQ_ALLOC) ? next_pid_ff + 1'b1 : req_pid;
      end
   end

   assign fpkt[0]    = '0;
   assign f_best[0]  = '0;
   assign f_prev[0]  = '0;
   assign f_next[0]  = '0;
   assign f_spare[0] = '0;
   assign upkt[0]    = '0;
   assign u_slot[0]  = '0;
   assign u_found[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < USED_ENTRIES; gi++) begin : g_used
         vpa_used_cell #(.IW(UIW), .IDX(UIW'(gi))) u_cell (
            .clock        (clock),
            .reset        (reset),
            .init_en      (init.en),
            .wr           (uwr),
            .wr_idx       (uwr_idx),
            .pid          (pid_ff),
            .pkt_in       (upkt[gi]),
            .slot_idx_in  (u_slot[gi]),
            .found_idx_in (u_found[gi]),
            .pkt_out      (upkt[gi+1]),
            .slot_idx_out (u_slot[gi+1]),
            .found_idx_out(u_found[gi+1])
         );
      end
      for (gi = 0; gi < FREE_ENTRIES; gi++) begin : g_free
         vpa_free_cell #(.IW(FIW), .IDX(FIW'(gi))) u_cell (
            .clock        (clock),
            .reset        (reset),
            .init         (init),
            .wr           (fwr),
            .wr_idx       (fwr_idx),
            .clr_en       (clr_en),
            .clr_idx      (clr_idx),
            .size         (size_ff),
            .bs           (upkt[USED_ENTRIES].found_start),
            .bl           (upkt[USED_ENTRIES].found_len),
            .policy       (policy_ff),
            .pkt_in       (fpkt[gi]),
            .best_idx_in  (f_best[gi]),
            .prev_idx_in  (f_prev[gi]),
            .next_idx_in  (f_next[gi]),
            .spare_idx_in (f_spare[gi]),
            .pkt_out      (fpkt[gi+1]),
            .best_idx_out (f_best[gi+1]),
            .prev_idx_out (f_prev[gi+1]),
            .next_idx_out (f_next[gi+1]),
            .spare_idx_out(f_spare[gi+1])
         );
      end
   endgenerate

   assign fo = fpkt[FREE_ENTRIES];
   assign uo = upkt[USED_ENTRIES];

   assign left      = fo.best_len - size_ff;
   assign merge_len = {2'b0, fo.prev_len} + {2'b0, uo.found_len} + {2'b0, fo.next_len};

   always_comb begin
      fwr      = '0;
      fwr_idx  = '0;
      clr_en   = 1'b0;
      clr_idx  = f_next[FREE_ENTRIES];
      uwr      = '0;
      uwr_idx  = '0;
      c_status = vpa_pkg::STAT_OK;
      c_start  = '0;
      c_len    = '0;
      if (type_ff == vpa_pkg::REQ_ALLOC) begin
         if (size_ff == '0) begin
            c_status = vpa_pkg::STAT_BAD_SIZE;
         end else if (!uo.has_slot) begin
            c_status = vpa_pkg::STAT_FULL;
         end else if (!fo.has_best) begin
            c_status = vpa_pkg::STAT_NO_FIT;
         end else begin
            c_start = fo.best_start;
            fwr.en  = 1'b1;
            fwr_idx = f_best[FREE_ENTRIES];
            if (left > {1'b0, min_slice_ff}) begin
               c_len     = size_ff;
               fwr.valid = 1'b1;
               fwr.start = fo.best_start + size_ff;
               fwr.len   = left;
            end else begin
               c_len     = fo.best_len;
               fwr.valid = 1'b0;
               fwr.start = fo.best_start;
               fwr.len   = fo.best_len;
            end
            uwr.en    = 1'b1;
            uwr.valid = 1'b1;
            uwr.owner = gpid_ff;
            uwr.start = c_start;
            uwr.len   = c_len;
            uwr_idx   = u_slot[USED_ENTRIES];
         end
      end else begin
         if (!uo.found) begin
            c_status = vpa_pkg::STAT_NOT_FOUND;
         end else begin
            fwr.en    = 1'b1;
            fwr.valid = 1'b1;
            if (fo.has_prev && fo.has_next) begin
               fwr_idx   = f_prev[FREE_ENTRIES];
               fwr.start = fo.prev_start;
               fwr.len   = merge_len[16:0];
               clr_en    = 1'b1;
            end else if (fo.has_prev) begin
               fwr_idx   = f_prev[FREE_ENTRIES];
               fwr.start = fo.prev_start;
               fwr.len   = fo.prev_len + uo.found_len;
            end else if (fo.has_next) begin
               fwr_idx   = f_next[FREE_ENTRIES];
               fwr.start = uo.found_start;
               fwr.len   = fo.next_len + uo.found_len;
            end else if (fo.has_spare) begin
               fwr_idx   = f_spare[FREE_ENTRIES];
               fwr.start = uo.found_start;
               fwr.len   = uo.found_len;
            end else begin
               fwr.en   = 1'b0;
               c_status = vpa_pkg::STAT_FULL;
            end
            if (fwr.en) begin
               c_start   = uo.found_start;
               c_len     = uo.found_len;
               uwr.en    = 1'b1;
               uwr.valid = 1'b0;
               uwr_idx   = u_found[USED_ENTRIES];
            end
         end
      end
      if (!commit_go) begin
         fwr.en = 1'b0;
         clr_en = 1'b0;
         uwr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         status_ff  <= c_status;
         rsp_pid_ff <= gpid_ff;
         start_ff   <= c_start;
         len_ff     <= c_len;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_granted_pid = rsp_pid_ff;
   assign rsp_block_start = start_ff;
   assign rsp_block_size  = len_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit_go |=> rsp_valid_ff)
      else $error("Committed item did not reach the output register.");

   a_ok_has_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == vpa_pkg::STAT_OK) |-> (len_ff != '0))
      else $error("Successful item reports an empty block.");

   a_pid_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == vpa_pkg::REQ_ALLOC) |=>
         (next_pid_ff == $past(next_pid_ff) + 16'd1))
      else $error("Process id did not advance on allocate.");

   a_no_double_write: assert property (@(posedge clock) disable iff (reset)
      (fwr.en && clr_en) |-> (fwr_idx != clr_idx))
      else $error("Merge writes and clears the same free entry.");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for variable_partition_allocator.
// Depends on vpa_pkg and the allocator RTL; it checks each result against an
// internal model of both block tables under random idling on both channels.
`timescale 1ns / 100ps

module tb_top;

   localparam int NFREE = vpa_pkg::FREE_ENTRIES_DEF;
   localparam int NUSED = vpa_pkg::USED_ENTRIES_DEF;
   localparam int IDLE_WAIT = 200;
   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] pid;
      logic [16:0] start;
      logic [16:0] size;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [16:0] req_size;
   logic [15:0] req_pid;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_granted_pid;
   logic [16:0] rsp_block_start;
   logic [16:0] rsp_block_size;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;

   int unsigned      cfg_size, cfg_base, cfg_policy, cfg_slice;
   int unsigned      free_addr [NFREE];
   int unsigned      free_span [NFREE];
   bit               free_used [NFREE];
   int unsigned      owner_pid [NUSED];
   int unsigned      owner_addr [NUSED];
   int unsigned      owner_span [NUSED];
   bit               owner_live [NUSED];
   int unsigned      pid_counter;
   alloc_result_type pending_results [$];
   logic [15:0]      live_pids [$];
   int               fail_count;
   int               idle_cycles;
   int               alloc_percent;

   variable_partition_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_size(req_size), .req_pid(req_pid),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_granted_pid(rsp_granted_pid), .rsp_block_start(rsp_block_start),
      .rsp_block_size(rsp_block_size),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_tables();
      for (int i = 0; i < NFREE; i++) free_used[i] = 1'b0;
      for (int i = 0; i < NUSED; i++) owner_live[i] = 1'b0;
      free_addr[0] = cfg_base;
      free_span[0] = cfg_size;
      free_used[0] = 1'b1;
      live_pids.delete();
   endfunction

   function automatic bit beats_current(int c, int b);
      bit lower;
      lower = free_addr[c] < free_addr[b];
      if (cfg_policy == vpa_pkg::FIT_BEST)
         return free_span[c] < free_span[b] || (free_span[c] == free_span[b] && lower);
      if (cfg_policy == vpa_pkg::FIT_WORST)
         return free_span[c] > free_span[b] || (free_span[c] == free_span[b] && lower);
      return lower;
   endfunction

   function automatic alloc_result_type predict_allocation(logic kind, int unsigned sz,
                                                           int unsigned pid);
      alloc_result_type r;
      int slot, best, prev, next, spare, u;
      int unsigned bs, bl;
      r = '0;
      slot = -1; best = -1; prev = -1; next = -1; spare = -1; u = -1;
      if (kind == vpa_pkg::REQ_ALLOC) begin
         pid_counter = (pid_counter + 1) & 16'hFFFF;
         r.pid = 16'(pid_counter);
         if (sz == 0) begin
            r.status = vpa_pkg::STAT_BAD_SIZE;
            return r;
         end
         for (int i = 0; i < NUSED && slot < 0; i++) if (!owner_live[i]) slot = i;
         if (slot < 0) begin
            r.status = vpa_pkg::STAT_FULL;
            return r;
         end
         for (int i = 0; i < NFREE; i++)
            if (free_used[i] && free_span[i] >= sz && (best < 0 || beats_current(i, best)))
               best = i;
         if (best < 0) begin
            r.status = vpa_pkg::STAT_NO_FIT;
            return r;
         end
         bs = free_addr[best];
         if (free_span[best] - sz > cfg_slice) begin
            bl = sz;
            free_addr[best] += sz;
            free_span[best] -= sz;
         end else begin
            bl = free_span[best];
            free_used[best] = 1'b0;
         end
         owner_pid[slot] = pid_counter;
         owner_addr[slot] = bs;
         owner_span[slot] = bl;
         owner_live[slot] = 1'b1;
      end else begin
         r.pid = 16'(pid);
         for (int i = 0; i < NUSED && u < 0; i++)
            if (owner_live[i] && owner_pid[i] == pid) u = i;
         if (u < 0) begin
            r.status = vpa_pkg::STAT_NOT_FOUND;
            return r;
         end
         bs = owner_addr[u];
         bl = owner_span[u];
         for (int i = 0; i < NFREE; i++) begin
            if (!free_used[i]) begin
               if (spare < 0) spare = i;
            end else if (free_addr[i] + free_span[i] == bs) begin
               prev = i;
            end else if (free_addr[i] == bs + bl) begin
               next = i;
            end
         end
         if (prev >= 0 && next >= 0) begin
            free_span[prev] += bl + free_span[next];
            free_used[next] = 1'b0;
         end else if (prev >= 0) begin
            free_span[prev] += bl;
         end else if (next >= 0) begin
            free_addr[next] = bs;
            free_span[next] += bl;
         end else if (spare >= 0) begin
            free_addr[spare] = bs;
            free_span[spare] = bl;
            free_used[spare] = 1'b1;
         end else begin
            r.status = vpa_pkg::STAT_FULL;
            return r;
         end
         owner_live[u] = 1'b0;
      end
      r.status = vpa_pkg::STAT_OK;
      r.start = 17'(bs);
      r.size = 17'(bl);
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   task automatic send_item(logic kind, logic [16:0] sz, logic [15:0] pid);
      alloc_result_type r;
      int gap;
      int idx;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_size = sz;
      req_pid = pid;
      do @(posedge clock); while (req_stall);
      r = predict_allocation(kind, {15'd0, sz}, {16'd0, pid});
      pending_results.push_back(r);
      if (r.status == vpa_pkg::STAT_OK) begin
         if (kind == vpa_pkg::REQ_ALLOC) begin
            live_pids.push_back(r.pid);
         end else begin
            for (idx = 0; idx < live_pids.size(); idx++)
               if (live_pids[idx] == pid) break;
            if (idx < live_pids.size()) live_pids.delete(idx);
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         vpa_pkg::REG_MEM_SIZE: begin
            if (value == 0) cfg_size = 1;
            else if (value > vpa_pkg::MAX_MEM_SIZE) cfg_size = vpa_pkg::MAX_MEM_SIZE;
            else cfg_size = value;
            clear_tables();
         end
         vpa_pkg::REG_MEM_BASE: begin
            cfg_base = value[15:0];
            clear_tables();
         end
         vpa_pkg::REG_FIT_POLICY: cfg_policy = value[1:0];
         vpa_pkg::REG_MIN_SLICE: cfg_slice = value[15:0];
         default: ;
      endcase
   endtask

   task automatic random_item();
      logic [16:0] sz;
      int roll;
      if ($urandom_range(0, 99) < alloc_percent) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) sz = 17'($urandom_range(1, 64));
         else if (roll < 80) sz = 17'($urandom_range(1, cfg_size));
         else if (roll < 85) sz = 17'd0;
         else if (roll < 90) sz = vpa_pkg::MAX_MEM_SIZE;
         else sz = 17'($urandom);
         send_item(vpa_pkg::REQ_ALLOC, sz, 16'($urandom));
      end else if (live_pids.size() != 0 && $urandom_range(0, 99) < 80) begin
         send_item(vpa_pkg::REQ_FREE, 17'($urandom),
                   live_pids[$urandom_range(0, live_pids.size() - 1)]);
      end else begin
         send_item(vpa_pkg::REQ_FREE, 17'($urandom), 16'($urandom));
      end
   endtask

   task automatic test_size_limits();
      send_item(vpa_pkg::REQ_ALLOC, 17'd0, 16'hFFFF);
      send_item(vpa_pkg::REQ_ALLOC, vpa_pkg::MAX_MEM_SIZE, 16'h0000);
      send_item(vpa_pkg::REQ_ALLOC, 17'd1025, 16'h0000);
      send_item(vpa_pkg::REQ_ALLOC, 17'd1020, 16'h0000);
      send_item(vpa_pkg::REQ_FREE, 17'h1FFFF, 16'd4);
      send_item(vpa_pkg::REQ_FREE, 17'd0, 16'hFFFF);
   endtask

   task automatic test_split_and_merge();
      send_item(vpa_pkg::REQ_ALLOC, 17'd100, 16'd0);
      send_item(vpa_pkg::REQ_ALLOC, 17'd200, 16'd0);
      send_item(vpa_pkg::REQ_ALLOC, 17'd50, 16'd0);
      send_item(vpa_pkg::REQ_ALLOC, 17'd300, 16'd0);
      send_item(vpa_pkg::REQ_FREE, 17'd0, 16'd8);
      send_item(vpa_pkg::REQ_FREE, 17'd0, 16'd10);
      send_item(vpa_pkg::REQ_FREE, 17'd0, 16'd9);
      send_item(vpa_pkg::REQ_ALLOC, 17'd370, 16'd0);
      send_item(vpa_pkg::REQ_FREE, 17'd0, 16'd7);
   endtask

   task automatic test_fit_policies();
      for (int p = 1; p < 4; p++) begin
         wait_idle();
         write_reg(vpa_pkg::REG_MEM_BASE, 17'h0FFFF);
         write_reg(vpa_pkg::REG_FIT_POLICY, 17'(p));
         send_item(vpa_pkg::REQ_ALLOC, 17'd40, 16'd0);
         send_item(vpa_pkg::REQ_ALLOC, 17'd30, 16'd0);
         send_item(vpa_pkg::REQ_ALLOC, 17'd40, 16'd0);
         send_item(vpa_pkg::REQ_ALLOC, 17'd30, 16'd0);
         send_item(vpa_pkg::REQ_FREE, 17'd0, 16'(pid_counter - 3));
         send_item(vpa_pkg::REQ_FREE, 17'd0, 16'(pid_counter - 1));
         send_item(vpa_pkg::REQ_ALLOC, 17'd25, 16'd0);
      end
   endtask

   task automatic test_random_phase(int items, logic [16:0] sz, logic [16:0] base,
                                    logic [1:0] policy, logic [16:0] slice, int pct);
      wait_idle();
      write_reg(vpa_pkg::REG_MEM_SIZE, sz);
      write_reg(vpa_pkg::REG_MEM_BASE, base);
      write_reg(vpa_pkg::REG_FIT_POLICY, {15'd0, policy});
      write_reg(vpa_pkg::REG_MIN_SLICE, slice);
      alloc_percent = pct;
      repeat (items) random_item();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         int run;
         int roll;
         @(negedge clock);
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            rsp_stall = 1'b0;
            run = $urandom_range(1, 300);
         end else if (roll < 90) begin
            rsp_stall = 1'($urandom_range(0, 1));
            run = $urandom_range(1, 4);
         end else begin
            rsp_stall = 1'b1;
            run = $urandom_range(20, 150);
         end
         repeat (run - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d pid %0d start %0d size %0d",
                     $time, rsp_status, rsp_granted_pid, rsp_block_start, rsp_block_size);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               fail_count++;
            end
            if (rsp_granted_pid !== e.pid) begin
               $display("%0t: granted_pid expected %0d actual %0d",
                        $time, e.pid, rsp_granted_pid);
               fail_count++;
            end
            if (rsp_block_start !== e.start) begin
               $display("%0t: block_start expected %0d actual %0d",
                        $time, e.start, rsp_block_start);
               fail_count++;
            end
            if (rsp_block_size !== e.size) begin
               $display("%0t: block_size expected %0d actual %0d",
                        $time, e.size, rsp_block_size);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = vpa_pkg::REQ_ALLOC;
      req_size = '0;
      req_pid = '0;
      csr_we = 1'b0;
      csr_index = vpa_pkg::REG_MEM_SIZE;
      csr_wdata = '0;
      fail_count = 0;
      cfg_size = vpa_pkg::RST_MEM_SIZE;
      cfg_base = vpa_pkg::RST_MEM_BASE;
      cfg_policy = vpa_pkg::RST_POLICY;
      cfg_slice = vpa_pkg::RST_MIN_SLICE;
      pid_counter = 0;
      clear_tables();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_size_limits();
      test_split_and_merge();
      test_fit_policies();
      test_random_phase(160, 17'd1024, 17'd0, vpa_pkg::FIT_FIRST, 17'd10, 60);
      test_random_phase(160, 17'h1FFFF, 17'd65535, vpa_pkg::FIT_BEST, 17'd0, 80);
      test_random_phase(150, 17'd0, 17'd12345, vpa_pkg::FIT_WORST, 17'd65535, 55);
      test_random_phase(160, 17'd65536, 17'd0, vpa_pkg::FIT_FIRST, 17'd0, 85);
      test_random_phase(150, 17'd300, 17'd40000, 2'd3, 17'd3, 55);
      test_random_phase(160, 17'd4096, 17'd21845, vpa_pkg::FIT_BEST, 17'd43690, 60);
      test_random_phase(150, 17'd2000, 17'd999, vpa_pkg::FIT_WORST, 17'd5, 65);
      test_random_phase(160, 17'd700, 17'd65535, vpa_pkg::FIT_FIRST, 17'd1, 50);

      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
